>>> design/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

    localparam int CoordWidth = 16;
    localparam int FieldWidth = 16;
    localparam int CountWidth = 16;
    localparam int QueueDepth = 4;

    localparam logic [CountWidth-1:0] CountMax = '1;

    typedef struct packed {
        logic signed [FieldWidth-1:0] vertex_x;
        logic signed [FieldWidth-1:0] vertex_y;
        logic                         last;
    } t_vertex_in;

    typedef struct packed {
        logic                  is_convex;
        logic [CountWidth-1:0] vertex_count;
    } t_result;

    // position of a vertex inside its polygon
    typedef enum logic [1:0] {
        VC_FIRST  = 2'd0,
        VC_SECOND = 2'd1,
        VC_THIRD  = 2'd2,
        VC_MIDDLE = 2'd3
    } t_vclass;

    typedef struct packed {
        t_vclass               vclass;
        logic                  last;
        logic [CountWidth-1:0] count;
    } t_q_ctrl;

endpackage

`default_nettype wire

>>> design/pcc_front.sv
`default_nettype none

module pcc_front #(
    parameter int COORD_WIDTH = pcc_pkg::CoordWidth
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  pcc_pkg::t_vertex_in          i_vertex,
    input  wire                          i_q_full,
    output logic                         o_ready,
    output logic                         o_push,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y,
    output pcc_pkg::t_q_ctrl             o_ctrl
);
    import pcc_pkg::*;

    logic [CountWidth-1:0] r_count;
    logic [CountWidth-1:0] n_count;
    logic [CountWidth-1:0] count_inc;

    // keep the low coordinate bits, sign extended
    if (COORD_WIDTH <= FieldWidth) begin : g_narrow
        assign o_x = i_vertex.vertex_x[COORD_WIDTH-1:0];
        assign o_y = i_vertex.vertex_y[COORD_WIDTH-1:0];
    end else begin : g_wide
        assign o_x = COORD_WIDTH'(i_vertex.vertex_x);
        assign o_y = COORD_WIDTH'(i_vertex.vertex_y);
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign count_inc = (r_count == CountMax) ? r_count : r_count + 1'b1;

    always_comb begin
        unique case (r_count)
            CountWidth'(0): o_ctrl.vclass = VC_FIRST;
            CountWidth'(1): o_ctrl.vclass = VC_SECOND;
            CountWidth'(2): o_ctrl.vclass = VC_THIRD;
            default:        o_ctrl.vclass = VC_MIDDLE;
        endcase
        o_ctrl.last  = i_vertex.last;
        o_ctrl.count = count_inc;
    end

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            n_count = i_vertex.last ? '0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> design/pcc_fifo.sv
`default_nettype none

module pcc_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = pcc_pkg::QueueDepth
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AddrW-1:0]  r_wr_ptr;
    logic [AddrW-1:0]  r_rd_ptr;
    logic [AddrW:0]    r_count;

    assign o_full  = (r_count == (AddrW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AddrW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AddrW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/pcc_back.sv
`default_nettype none

module pcc_back #(
    parameter int COORD_WIDTH = pcc_pkg::CoordWidth
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_q_valid,
    input  wire signed [COORD_WIDTH-1:0]  i_x,
    input  wire signed [COORD_WIDTH-1:0]  i_y,
    input  pcc_pkg::t_q_ctrl              i_ctrl,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire                           i_ready,
    output pcc_pkg::t_result              o_result
);
    import pcc_pkg::*;

    localparam int DiffW = COORD_WIDTH + 1;
    localparam int ProdW = 2 * DiffW;
    localparam int CrossW = ProdW + 1;
    localparam int NumTurns = 3;

    logic signed [COORD_WIDTH-1:0] r_first_x, r_first_y;
    logic signed [COORD_WIDTH-1:0] r_second_x, r_second_y;
    logic signed [COORD_WIDTH-1:0] r_older_x, r_older_y;
    logic signed [COORD_WIDTH-1:0] r_newer_x, r_newer_y;

    logic signed [COORD_WIDTH-1:0] ax [NumTurns];
    logic signed [COORD_WIDTH-1:0] ay [NumTurns];
    logic signed [COORD_WIDTH-1:0] bx [NumTurns];
    logic signed [COORD_WIDTH-1:0] by [NumTurns];
    logic signed [COORD_WIDTH-1:0] cx [NumTurns];
    logic signed [COORD_WIDTH-1:0] cy [NumTurns];

    logic signed [ProdW-1:0] n_pa [NumTurns];
    logic signed [ProdW-1:0] n_pb [NumTurns];
    logic signed [ProdW-1:0] r_pa [NumTurns];
    logic signed [ProdW-1:0] r_pb [NumTurns];
    logic                    pos  [NumTurns];

    logic    r_s1_valid;
    t_q_ctrl r_s1_ctrl;
    logic    s1_go;
    logic    out_free;

    logic    r_turn_sign;
    logic    r_convex;
    logic    is_turn;
    logic    sign_ref;
    logic    bad;
    logic    conv;
    logic    r_out_valid;
    t_result r_out;

    // turn 0: older, newer, new vertex; turns 1 and 2 close the polygon
    always_comb begin
        ax[0] = r_older_x;  ay[0] = r_older_y;
        bx[0] = r_newer_x;  by[0] = r_newer_y;
        cx[0] = i_x;        cy[0] = i_y;
        ax[1] = r_newer_x;  ay[1] = r_newer_y;
        bx[1] = i_x;        by[1] = i_y;
        cx[1] = r_first_x;  cy[1] = r_first_y;
        ax[2] = i_x;        ay[2] = i_y;
        bx[2] = r_first_x;  by[2] = r_first_y;
        cx[2] = r_second_x; cy[2] = r_second_y;
    end

    for (genvar t = 0; t < NumTurns; t++) begin : g_turn
        logic signed [DiffW-1:0]  e1x, e1y, e2x, e2y;
        logic signed [CrossW-1:0] cross_prod;

        assign e1x = DiffW'(bx[t]) - DiffW'(ax[t]);
        assign e1y = DiffW'(by[t]) - DiffW'(ay[t]);
        assign e2x = DiffW'(cx[t]) - DiffW'(bx[t]);
        assign e2y = DiffW'(cy[t]) - DiffW'(by[t]);
        assign n_pa[t] = ProdW'(e1x) * ProdW'(e2y);
        assign n_pb[t] = ProdW'(e1y) * ProdW'(e2x);

        assign cross_prod = CrossW'(r_pa[t]) - CrossW'(r_pb[t]);
        // strictly positive: sign clear and not zero
        assign pos[t]     = !cross_prod[CrossW-1] && (cross_prod != '0);

        always_ff @(posedge i_clk) begin
            if (o_pop) begin
                r_pa[t] <= n_pa[t];
                r_pb[t] <= n_pb[t];
            end
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign s1_go    = r_s1_valid && (!r_s1_ctrl.last || out_free);
    assign o_pop    = i_q_valid && (!r_s1_valid || s1_go);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_ctrl.vclass == VC_FIRST) begin
                r_first_x <= i_x;
                r_first_y <= i_y;
            end
            if (i_ctrl.vclass == VC_SECOND) begin
                r_second_x <= i_x;
                r_second_y <= i_y;
            end
            r_older_x <= r_newer_x;
            r_older_y <= r_newer_y;
            r_newer_x <= i_x;
            r_newer_y <= i_y;
            r_s1_ctrl <= i_ctrl;
        end
    end

    // fold the turn outcomes
    always_comb begin
        is_turn  = (r_s1_ctrl.vclass == VC_THIRD) || (r_s1_ctrl.vclass == VC_MIDDLE);
        sign_ref = (r_s1_ctrl.vclass == VC_THIRD) ? pos[0] : r_turn_sign;
        bad      = ((r_s1_ctrl.vclass == VC_MIDDLE) && (pos[0] != r_turn_sign))
                || (r_s1_ctrl.last && is_turn
                    && ((pos[1] != sign_ref) || (pos[2] != sign_ref)));
        conv     = r_convex && !bad;
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_ctrl.last) begin
            r_out.is_convex    <= is_turn && conv;
            r_out.vertex_count <= r_s1_ctrl.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_turn_sign <= 1'b0;
            r_convex    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                if (r_s1_ctrl.last) begin
                    r_turn_sign <= 1'b0;
                    r_convex    <= 1'b1;
                end else begin
                    if (r_s1_ctrl.vclass == VC_THIRD) begin
                        r_turn_sign <= pos[0];
                    end
                    r_convex <= conv;
                end
            end

            if (s1_go && r_s1_ctrl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

>>> design/polygon_convexity_check_core.sv
// a result is valid once the last vertex has passed the queue, the product registers and the output register
// throughput: one vertex per cycle, sustained unless the result output stalls; at most one result per polygon
// the rate is set by the back pipeline (edge products, then sign fold), one item per stage
// reset: i_rst_n synchronous, active low; clears the vertex counter, queue,
// pipeline valids and the turn fold, so the next vertex starts a new polygon
`default_nettype none

module polygon_convexity_check_core #(
    parameter int COORD_WIDTH = pcc_pkg::CoordWidth,
    parameter int QUEUE_DEPTH = pcc_pkg::QueueDepth
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  pcc_pkg::t_vertex_in  i_vertex,
    output logic                 o_valid,
    input  wire                  i_ready,
    output pcc_pkg::t_result     o_result
);
    import pcc_pkg::*;

    localparam int CtrlW = $bits(t_q_ctrl);
    localparam int QDataW = 2 * COORD_WIDTH + CtrlW;

    // front side: sign extend, classify by position in the polygon
    logic                          push;
    logic                          q_full;
    logic signed [COORD_WIDTH-1:0] f_x, f_y;
    t_q_ctrl                       f_ctrl;

    // queue between front and back
    logic              q_valid;
    logic              pop;
    logic [QDataW-1:0] q_data;

    // back side view of the queue head
    logic signed [COORD_WIDTH-1:0] b_x, b_y;
    t_q_ctrl                       b_ctrl;

    pcc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_vertex (i_vertex),
        .i_q_full (q_full),
        .o_ready  (o_ready),
        .o_push   (push),
        .o_x      (f_x),
        .o_y      (f_y),
        .o_ctrl   (f_ctrl)
    );

    pcc_fifo #(
        .DATA_W (QDataW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_x, f_y, f_ctrl}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // unpack the queue head
    assign b_x    = q_data[QDataW-1 -: COORD_WIDTH];
    assign b_y    = q_data[CtrlW +: COORD_WIDTH];
    assign b_ctrl = q_data[CtrlW-1:0];

    // back side: cross products, turn fold, output register
    pcc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_x       (b_x),
        .i_y       (b_y),
        .i_ctrl    (b_ctrl),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

>>> tb/tb_polygon_convexity_check_core.sv
`default_nettype none

module tb_polygon_convexity_check_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_vertex_in i_vertex;
    logic       o_valid;
    logic       i_ready;
    t_result    o_result;

    // 12 ns period
    always #6 i_clk = ~i_clk;

    polygon_convexity_check_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_vertex (i_vertex),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    localparam real TwoPi       = 6.283185307179586;
    localparam int  PhaseItems  = 263;   // random vertices per idling phase
    localparam int  SettleCycles = 4;    // extra edges waited once every verdict is back

    // ------------------------------------------------------------------
    // scoreboard storage
    // ------------------------------------------------------------------
    // per-vertex note: a directed row may carry a hand-written verdict
    typedef struct packed {
        bit      typed;
        t_result want;
    } t_vertex_note;

    t_vertex_note vertex_notes[$];     // one per vertex driven, popped on acceptance
    t_result      pending_verdicts[$]; // verdicts still owed by the block

    int error_count = 0;
    int items_sent  = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // ------------------------------------------------------------------
    // convexity predictor: own copy of the polygon state
    // ------------------------------------------------------------------
    typedef struct packed {
        longint x;
        longint y;
    } t_point;

    t_point poly_first, poly_second, poly_older, poly_newer;
    int     poly_count;
    bit     turn_is_left;   // outcome of the opening turn
    bit     still_convex;

    function automatic void clear_polygon();
        poly_first   = '{0, 0};
        poly_second  = '{0, 0};
        poly_older   = '{0, 0};
        poly_newer   = '{0, 0};
        poly_count   = 0;
        turn_is_left = 1'b0;
        still_convex = 1'b1;
    endfunction

    // low CoordWidth bits, sign-extended
    function automatic longint coord_value(logic [FieldWidth-1:0] raw);
        longint unsigned low;
        low = longint'(raw) & ((64'd1 << CoordWidth) - 64'd1);
        if (low[CoordWidth-1])
            return longint'(low) - (longint'(1) << CoordWidth);
        return longint'(low);
    endfunction

    // strictly positive cross product of edges a->b, b->c; zero is not a left turn
    function automatic bit turns_left(t_point a, t_point b, t_point c);
        longint cp;
        cp = (b.x - a.x) * (c.y - b.y) - (b.y - a.y) * (c.x - b.x);
        return cp > 0;
    endfunction

    function automatic void fold_turn(bit left, bit opening);
        if (opening)
            turn_is_left = left;
        else if (left != turn_is_left)
            still_convex = 1'b0;
    endfunction

    // returns 1 when the vertex closes a polygon, with the verdict in r
    function automatic bit predict_vertex(input t_vertex_in v, output t_result r);
        t_point p;
        int     seen_before;
        seen_before = poly_count;
        p.x = coord_value(v.vertex_x);
        p.y = coord_value(v.vertex_y);
        r = '0;

        if (seen_before == 0)
            poly_first = p;
        else if (seen_before == 1)
            poly_second = p;
        else
            fold_turn(turns_left(poly_older, poly_newer, p), seen_before == 2);

        poly_older = poly_newer;
        poly_newer = p;
        if (poly_count < int'(CountMax))
            poly_count++;

        if (!v.last)
            return 1'b0;

        // two wrap-around turns close the loop
        if (poly_count >= 3) begin
            fold_turn(turns_left(poly_older, poly_newer, poly_first), 1'b0);
            fold_turn(turns_left(poly_newer, poly_first, poly_second), 1'b0);
            r.is_convex = still_convex;
        end
        r.vertex_count = poly_count[CountWidth-1:0];
        clear_polygon();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // receiver side: random stalls per phase
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: predict on each input transaction, check each output transaction
    // both handshakes sampled at the edge, before any nonblocking update lands
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_vertex_note note;
        t_result      verdict;
        t_result      want;
        bit           closes;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                note = '{1'b0, '0};
                if (vertex_notes.size() != 0)
                    note = vertex_notes.pop_front();
                closes = predict_vertex(i_vertex, verdict);
                if (note.typed)
                    verdict = note.want;
                if (closes)
                    pending_verdicts.push_back(verdict);
            end
            if (o_valid && i_ready) begin
                if (pending_verdicts.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result transaction is_convex %0b vertex_count %0d",
                             $time, o_result.is_convex, o_result.vertex_count);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_result.is_convex !== want.is_convex) begin
                        error_count++;
                        $display("%0t: is_convex mismatch expected %0b actual %0b",
                                 $time, want.is_convex, o_result.is_convex);
                    end
                    if (o_result.vertex_count !== want.vertex_count) begin
                        error_count++;
                        $display("%0t: vertex_count mismatch expected %0d actual %0d",
                                 $time, want.vertex_count, o_result.vertex_count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // valid goes high and stays high with a fixed payload until accepted
    task automatic send_vertex(input t_vertex_in v, input bit typed, input t_result want);
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        vertex_notes.push_back('{typed, want});
        i_valid  <= 1'b1;
        i_vertex <= v;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // sender holds off until every owed verdict is back
    task automatic drain_verdicts();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0 || vertex_notes.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic [FieldWidth-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return FieldWidth'($urandom);
        endcase
    endfunction

    // one random polygon: a circle loop, dented or not, or scattered, extreme or collinear points
    task automatic send_random_polygon();
        t_vertex_in pts[$];
        t_vertex_in v;
        int         kind, n, cx, cy, rad, dir, acc, wsum, j, bx, by, sx, sy;
        int         weights[$];
        real        start, ang;
        kind = $urandom_range(0, 99);
        v = '0;
        if (kind < 45 || kind >= 90) begin
            // points on a circle with increasing angle, either winding
            n   = $urandom_range(3, 12);
            cx  = int'($urandom_range(0, 32000)) - 16000;
            cy  = int'($urandom_range(0, 32000)) - 16000;
            rad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(20, 16000);
            dir = $urandom_range(0, 1) ? 1 : -1;
            wsum = 0;
            for (j = 0; j < n; j++) begin
                weights.push_back($urandom_range(1, 100));
                wsum += weights[j];
            end
            start = TwoPi * real'($urandom_range(0, 999)) / 1000.0;
            acc = 0;
            for (j = 0; j < n; j++) begin
                ang = start + TwoPi * real'(acc) / real'(wsum);
                acc += weights[j];
                v.vertex_x = FieldWidth'(cx + $rtoi(real'(rad) * $cos(ang)));
                v.vertex_y = FieldWidth'(cy + dir * $rtoi(real'(rad) * $sin(ang)));
                pts.push_back(v);
            end
            // dent: pull one vertex to the center
            if (kind >= 90) begin
                j = $urandom_range(0, n - 1);
                pts[j].vertex_x = FieldWidth'(cx);
                pts[j].vertex_y = FieldWidth'(cy);
            end
        end else if (kind < 70) begin
            // scattered points over the whole range, short ones included
            n = (kind < 60) ? $urandom_range(3, 8) : $urandom_range(1, 2);
            for (j = 0; j < n; j++) begin
                v.vertex_x = FieldWidth'($urandom);
                v.vertex_y = FieldWidth'($urandom);
                pts.push_back(v);
            end
        end else if (kind < 80) begin
            n = $urandom_range(3, 6);
            for (j = 0; j < n; j++) begin
                v.vertex_x = pick_extreme();
                v.vertex_y = pick_extreme();
                pts.push_back(v);
            end
        end else begin
            // collinear run: every turn degenerate
            n  = $urandom_range(3, 6);
            bx = int'($urandom_range(0, 2000)) - 1000;
            by = int'($urandom_range(0, 2000)) - 1000;
            sx = int'($urandom_range(0, 400)) - 200;
            sy = int'($urandom_range(0, 400)) - 200;
            for (j = 0; j < n; j++) begin
                v.vertex_x = FieldWidth'(bx + j * sx);
                v.vertex_y = FieldWidth'(by + j * sy);
                pts.push_back(v);
            end
        end
        foreach (pts[k]) begin
            pts[k].last = (k == pts.size() - 1);
            send_vertex(pts[k], 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct packed {
        int x;
        int y;
        bit last;
        bit typed;
        bit want_convex;
        int want_count;
    } t_directed_row;

    localparam int DirectedRows = 24;

    t_directed_row directed_rows [DirectedRows] = '{
        // lone vertex right after reset
        '{0, 0, 1, 1, 0, 1},
        // two-vertex polygon at the coordinate extremes
        '{32767, -32768, 0, 0, 0, 0},
        '{-32768, 32767, 1, 1, 0, 2},
        // counterclockwise triangle
        '{0, 0, 0, 0, 0, 0},
        '{100, 0, 0, 0, 0, 0},
        '{0, 100, 1, 1, 1, 3},
        // clockwise triangle: all turns negative, still convex
        '{0, 0, 0, 0, 0, 0},
        '{0, 100, 0, 0, 0, 0},
        '{100, 0, 1, 1, 1, 3},
        // collinear points, zero products
        '{1, 1, 0, 0, 0, 0},
        '{2, 2, 0, 0, 0, 0},
        '{3, 3, 1, 0, 0, 0},
        // full-range square
        '{-32768, -32768, 0, 0, 0, 0},
        '{32767, -32768, 0, 0, 0, 0},
        '{32767, 32767, 0, 0, 0, 0},
        '{-32768, 32767, 1, 1, 1, 4},
        // dart with one reflex corner
        '{0, 0, 0, 0, 0, 0},
        '{100, 0, 0, 0, 0, 0},
        '{10, 10, 0, 0, 0, 0},
        '{0, 100, 1, 0, 0, 0},
        // repeated vertex
        '{5, 5, 0, 0, 0, 0},
        '{5, 5, 0, 0, 0, 0},
        '{-5, -5, 0, 0, 0, 0},
        '{5, 5, 1, 0, 0, 0}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_vertex_in v;
        t_result    want;
        int         phase;
        int         random_base;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_vertex = '0;
        clear_polygon();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, no idling
        for (int r = 0; r < DirectedRows; r++) begin
            v = '0;
            v.vertex_x = FieldWidth'(directed_rows[r].x);
            v.vertex_y = FieldWidth'(directed_rows[r].y);
            v.last     = directed_rows[r].last;
            want.is_convex    = directed_rows[r].want_convex;
            want.vertex_count = CountWidth'(directed_rows[r].want_count);
            send_vertex(v, directed_rows[r].typed, want);
        end
        drain_verdicts();

        // random polygons over four idling phases
        random_base = items_sent;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            while (items_sent - random_base < (phase + 1) * PhaseItems)
                send_random_polygon();
            drain_verdicts();
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
